>>> design/boot_entry_list_parser_assert.svh
// assertion macros for the parser modules; only bel_queue includes them
`ifndef BOOT_ENTRY_LIST_PARSER_ASSERT_SVH
`define BOOT_ENTRY_LIST_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// property checked while reset is low
`define BEL_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("parser assertion failed");
// property checked on every edge, reset included
`define BEL_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("parser assertion failed");
`else
`define BEL_ASSERT(lbl, clk, rst, prop)
`define BEL_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> design/bel_pkg.sv
// types, constants and helper functions of the boot entry list parser
package bel_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int TEXT_LEN    = 4096;

   localparam int POS_W = 12;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   localparam logic [POS_W-1:0] LEN_MAX   = 12'd4095;
   localparam logic [POS_W-1:0] POS_LIMIT =
      POS_W'(((TEXT_LEN - 1) < 4095) ? (TEXT_LEN - 1) : 4095);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_NUL      = 8'd0;
   localparam logic [7:0] CHAR_QUOTE    = 8'd34;
   localparam logic [7:0] CHAR_RBRACKET = 8'd93;
   localparam logic [2:0] KEYWORD_LEN   = 3'd7;

   typedef enum logic [2:0] {
      PH_SEEK,
      PH_KEY_WAIT,
      PH_KEY,
      PH_VALUE_WAIT,
      PH_PATH,
      PH_SKIP,
      PH_DONE
   } phase_type;

   localparam logic RESULT_ENTRY = 1'b0;
   localparam logic RESULT_END   = 1'b1;

   // work handed from the parser to the result stage
   typedef struct packed {
      logic             has_entry;
      logic             has_end;
      logic [3:0]       entry_index;
      logic [POS_W-1:0] name_start;
      logic [POS_W-1:0] name_length;
      logic [POS_W-1:0] path_start;
      logic [POS_W-1:0] path_length;
      logic [CNT_W-1:0] count;
      logic             overflow;
   } job_type;

   typedef struct packed {
      logic        result_kind;
      logic [3:0]  entry_index;
      logic [11:0] name_start;
      logic [11:0] name_length;
      logic [11:0] path_start;
      logic [11:0] path_length;
      logic [4:0]  entry_count;
      logic        overflow;
      logic        last_of_run;
   } result_type;

   function automatic logic is_alnum(input logic [7:0] b);
      return b inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
   endfunction

   // letters of "entries"
   function automatic logic [7:0] keyword_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h65;
         3'd1:    c = 8'h6e;
         3'd2:    c = 8'h74;
         3'd3:    c = 8'h72;
         3'd4:    c = 8'h69;
         3'd5:    c = 8'h65;
         3'd6:    c = 8'h73;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

>>> design/bel_channels.sv
// handshake channels of the boot entry list parser
interface bel_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       first_byte;

   modport source(output valid, output text_byte, output first_byte, input ready);
   modport sink(input valid, input text_byte, input first_byte, output ready);
endinterface

interface bel_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [3:0]  entry_index;
   logic [11:0] name_start;
   logic [11:0] name_length;
   logic [11:0] path_start;
   logic [11:0] path_length;
   logic [4:0]  entry_count;
   logic        overflow;
   logic        last_of_run;

   modport source(output valid, output result_kind, output entry_index, output name_start,
                  output name_length, output path_start, output path_length,
                  output entry_count, output overflow, output last_of_run, input ready);
   modport sink(input valid, input result_kind, input entry_index, input name_start,
                input name_length, input path_start, input path_length,
                input entry_count, input overflow, input last_of_run, output ready);
endinterface

>>> design/bel_front.sv
// parse state machine: classifies each byte and posts the records it causes
module bel_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       text_byte,
   input  logic             first_byte,
   output logic             push,
   output bel_pkg::job_type job
);
   import bel_pkg::*;

   phase_type        phase_ff, phase_in, cur_phase;
   logic [2:0]       kw_ff, kw_in, cur_kw;
   logic [POS_W-1:0] pos_ff, pos_in, cur_pos;
   logic [POS_W-1:0] ks_ff, ks_in, cur_ks;
   logic [POS_W-1:0] kl_ff, kl_in, cur_kl;
   logic [POS_W-1:0] vs_ff, vs_in, cur_vs;
   logic [POS_W-1:0] vl_ff, vl_in, cur_vl;
   logic [CNT_W-1:0] rec_ff, rec_in, cur_rec;
   logic             drop_ff, drop_in, cur_drop;
   logic             do_entry, do_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEEK;
         kw_ff    <= '0;
         pos_ff   <= '0;
         ks_ff    <= '0;
         kl_ff    <= '0;
         vs_ff    <= '0;
         vl_ff    <= '0;
         rec_ff   <= '0;
         drop_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         kw_ff    <= kw_in;
         pos_ff   <= pos_in;
         ks_ff    <= ks_in;
         kl_ff    <= kl_in;
         vs_ff    <= vs_in;
         vl_ff    <= vl_in;
         rec_ff   <= rec_in;
         drop_ff  <= drop_in;
      end
   end

   always_comb begin
      // a new text starts from cleared state
      cur_phase = first_byte ? PH_SEEK : phase_ff;
      cur_kw    = first_byte ? '0 : kw_ff;
      cur_pos   = first_byte ? '0 : pos_ff;
      cur_ks    = first_byte ? '0 : ks_ff;
      cur_kl    = first_byte ? '0 : kl_ff;
      cur_vs    = first_byte ? '0 : vs_ff;
      cur_vl    = first_byte ? '0 : vl_ff;
      cur_rec   = first_byte ? '0 : rec_ff;
      cur_drop  = first_byte ? 1'b0 : drop_ff;

      phase_in = cur_phase;
      kw_in    = cur_kw;
      ks_in    = cur_ks;
      kl_in    = cur_kl;
      vs_in    = cur_vs;
      vl_in    = cur_vl;
      rec_in   = cur_rec;
      drop_in  = cur_drop;
      do_entry = 1'b0;
      do_end   = 1'b0;

      case (cur_phase)
         PH_SEEK: begin
            if (text_byte == CHAR_NUL) begin
               do_end = 1'b1;
            end else if (cur_kw < KEYWORD_LEN && text_byte == keyword_char(cur_kw)) begin
               kw_in = cur_kw + 3'd1;
               if (kw_in >= KEYWORD_LEN) begin
                  phase_in = PH_KEY_WAIT;
               end
            end
         end
         PH_KEY_WAIT: begin
            if (text_byte == CHAR_NUL || text_byte == CHAR_RBRACKET) begin
               do_end = 1'b1;
            end else if (is_alnum(text_byte)) begin
               ks_in    = cur_pos;
               kl_in    = POS_W'(1);
               phase_in = PH_KEY;
            end
         end
         PH_KEY: begin
            if (is_alnum(text_byte)) begin
               if (cur_kl < LEN_MAX) begin
                  kl_in = cur_kl + 1'b1;
               end
            end else if (text_byte == CHAR_NUL) begin
               do_end = 1'b1;
            end else begin
               phase_in = PH_VALUE_WAIT;
            end
         end
         PH_VALUE_WAIT: begin
            if (text_byte == CHAR_NUL) begin
               do_end = 1'b1;
            end else if (text_byte == CHAR_QUOTE) begin
               vs_in    = (cur_pos < POS_LIMIT) ? cur_pos + 1'b1 : POS_LIMIT;
               vl_in    = '0;
               phase_in = PH_PATH;
            end
         end
         PH_PATH: begin
            if (text_byte == CHAR_QUOTE) begin
               do_entry = 1'b1;
               phase_in = PH_SKIP;
            end else if (text_byte == CHAR_NUL) begin
               do_entry = 1'b1;
               do_end   = 1'b1;
            end else if (cur_vl < LEN_MAX) begin
               vl_in = cur_vl + 1'b1;
            end
         end
         PH_SKIP: begin
            if (text_byte == CHAR_NUL) begin
               do_end = 1'b1;
            end else begin
               phase_in = PH_KEY_WAIT;
            end
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      job.has_entry   = 1'b0;
      job.entry_index = 4'(cur_rec);
      if (do_entry) begin
         if (cur_rec < CNT_W'(MAX_ENTRIES)) begin
            job.has_entry = 1'b1;
            rec_in        = cur_rec + 1'b1;
         end else begin
            drop_in = 1'b1;
         end
      end
      if (do_end) begin
         phase_in = PH_DONE;
      end

      job.has_end     = do_end;
      job.name_start  = cur_ks;
      job.name_length = cur_kl;
      job.path_start  = cur_vs;
      job.path_length = cur_vl;
      job.count       = rec_in;
      job.overflow    = drop_in;

      pos_in = (cur_pos < POS_LIMIT) ? cur_pos + 1'b1 : cur_pos;

      push = accept && (job.has_entry || job.has_end);

      if (!accept) begin
         phase_in = phase_ff;
         kw_in    = kw_ff;
         pos_in   = pos_ff;
         ks_in    = ks_ff;
         kl_in    = kl_ff;
         vs_in    = vs_ff;
         vl_in    = vl_ff;
         rec_in   = rec_ff;
         drop_in  = drop_ff;
      end
   end

endmodule

>>> design/bel_queue.sv
// short record queue between the parser and the result stage
`include "boot_entry_list_parser_assert.svh"
module bel_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bel_pkg::job_type job_in,
   output logic             full,
   input  logic             pop,
   output bel_pkg::job_type head,
   output logic             empty
);
   import bel_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in    = wr_ff;
      rd_in    = rd_ff;
      count_in = count_ff;
      if (push) begin
         wr_in = (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= job_in;
      end
   end

   `BEL_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `BEL_ASSERT(a_no_push_full, clock, reset, push |-> !full)
   `BEL_ASSERT(a_no_pop_empty, clock, reset, pop |-> !empty)
   `BEL_ASSERT(a_fill_tracks, clock, reset, (push && !pop) |=> count_ff == $past(count_ff) + 1'b1)

endmodule

>>> design/bel_back.sv
// result stage: turns queued records into result items behind an output register
module bel_back (
   input  logic                clock,
   input  logic                reset,
   input  bel_pkg::job_type    head,
   input  logic                empty,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output bel_pkg::result_type out_data
);
   import bel_pkg::*;

   logic       valid_ff, valid_in;
   logic       sub_ff, sub_in;
   logic       load;
   result_type res_ff, res_in, entry_res, end_res;

   assign out_valid = valid_ff;
   assign out_data  = res_ff;
   assign load      = !valid_ff || out_ready;

   always_comb begin
      entry_res.result_kind = RESULT_ENTRY;
      entry_res.entry_index = head.entry_index;
      entry_res.name_start  = head.name_start;
      entry_res.name_length = head.name_length;
      entry_res.path_start  = head.path_start;
      entry_res.path_length = head.path_length;
      entry_res.entry_count = 5'(head.count);
      entry_res.overflow    = head.overflow;
      entry_res.last_of_run = !head.has_end;

      end_res             = '0;
      end_res.result_kind = RESULT_END;
      end_res.entry_count = 5'(head.count);
      end_res.overflow    = head.overflow;
      end_res.last_of_run = 1'b1;

      pop      = 1'b0;
      sub_in   = sub_ff;
      valid_in = valid_ff;
      res_in   = res_ff;
      if (load) begin
         valid_in = 1'b0;
         if (!empty) begin
            valid_in = 1'b1;
            if (head.has_entry && !sub_ff) begin
               res_in = entry_res;
               if (head.has_end) begin
                  sub_in = 1'b1;
               end else begin
                  pop = 1'b1;
               end
            end else begin
               res_in = end_res;
               pop    = 1'b1;
               sub_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sub_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sub_ff   <= sub_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

endmodule

>>> design/boot_entry_list_parser.sv
// top level of the boot entry list parser
//
// req_if carries the text one byte per item (text_byte, first_byte); an
// item moves when valid and ready are both high at a rising clock edge.
// rsp_if carries result items: entry records and the end-of-list record.
// throughput: one byte per cycle while the queue is not full; the parse
// state machine updates in the cycle a byte is accepted, so bytes may
// follow each other back to back. a byte that causes results posts one
// record into the queue, and the result stage turns it into result items;
// a nul inside a path gives an entry item and then the end item, or only
// the end item once the entry list is full.
// a four-record queue sits between the parser and the output
// register: when the receiver stalls, records collect there and req ready
// drops only once the queue is full.
// reset (synchronous, active high) clears parse state, the queue and the
// output register; first_byte clears parse state for a new text.
module boot_entry_list_parser (
   input logic clock,
   input logic reset,
   bel_req_if.sink   req_if,
   bel_rsp_if.source rsp_if
);
   import bel_pkg::*;

   // front side handshake
   logic       q_full;
   logic       accept;
   logic       push;
   job_type    job;

   // queue to back side
   job_type    head;
   logic       q_empty;
   logic       pop;

   // output register
   result_type out_data;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;

   bel_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .text_byte  (req_if.text_byte),
      .first_byte (req_if.first_byte),
      .push       (push),
      .job        (job)
   );

   bel_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .job_in (job),
      .full   (q_full),
      .pop    (pop),
      .head   (head),
      .empty  (q_empty)
   );

   bel_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (out_data)
   );

   // unpack the result item onto the channel
   assign rsp_if.result_kind = out_data.result_kind;
   assign rsp_if.entry_index = out_data.entry_index;
   assign rsp_if.name_start  = out_data.name_start;
   assign rsp_if.name_length = out_data.name_length;
   assign rsp_if.path_start  = out_data.path_start;
   assign rsp_if.path_length = out_data.path_length;
   assign rsp_if.entry_count = out_data.entry_count;
   assign rsp_if.overflow    = out_data.overflow;
   assign rsp_if.last_of_run = out_data.last_of_run;

endmodule
